### rtl/core/pyc_pkg.sv
// ----------------------------------------------------------------------------
// pyc_pkg
// Types, codes and constants shared by the position and yaw PID controller.
// ----------------------------------------------------------------------------
package pyc_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_SETPOINT_X = 3'd0;
    localparam logic [2:0] REG_SETPOINT_Y = 3'd1;
    localparam logic [2:0] REG_POS_KP     = 3'd2;
    localparam logic [2:0] REG_POS_KI_DT  = 3'd3;
    localparam logic [2:0] REG_POS_KD     = 3'd4;
    localparam logic [2:0] REG_YAW_KP     = 3'd5;
    localparam logic [2:0] REG_YAW_KI_DT  = 3'd6;

    localparam logic [31:0] RST_SETPOINT_X = 32'hFFFF_0000;
    localparam logic [31:0] RST_SETPOINT_Y = 32'd196608;
    localparam logic [31:0] RST_POS_KP     = 32'd120796;
    localparam logic [31:0] RST_POS_KI_DT  = 32'd2689;
    localparam logic [31:0] RST_POS_KD     = 32'd3355443;
    localparam logic [31:0] RST_YAW_KP     = 32'd58720256;
    localparam logic [31:0] RST_YAW_KI_DT  = 32'd8589935;

    // Angles in Q.28 radians
    localparam logic signed [35:0] Q28_PI     = 36'sd843314857;
    localparam logic signed [35:0] Q28_TWO_PI = 36'sd1686629713;

    // Sequencer program points and last iteration indexes
    localparam logic [5:0] PC_HEAD_END = 6'd7;
    localparam logic [5:0] PC_ROT_END  = 6'd35;
    localparam logic [5:0] PC_YAW_END  = 6'd39;
    localparam logic [4:0] SQRT_LAST   = 5'd31;
    localparam logic [4:0] DIV_LAST    = 5'd31;
    localparam logic [4:0] CORD_LAST   = 5'd27;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_CAPTURE,
        OP_MAC,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_CORD_INIT,
        OP_CORD_STEP,
        OP_WRAP,
        OP_RESULT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [5:0] pc;
        logic [4:0] iter;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE, S_HEAD, S_SQRTI, S_SQRT, S_DIVI, S_DIV,
        S_ROT, S_CORDI, S_CORD, S_WRAP, S_YAW, S_OUT
    } t_state;

    typedef enum logic [3:0] {
        A_QW, A_QX, A_HC, A_HS, A_EX, A_EY, A_DX, A_DY,
        A_BEX, A_BEY, A_BDX, A_BDY, A_ERR
    } t_asel;

    typedef enum logic [3:0] {
        B_QW, B_QX, B_QY, B_QZ, B_HC, B_HS, B_C, B_S,
        B_KP, B_KI, B_KD, B_YKP, B_YKI
    } t_bsel;

    typedef enum logic [3:0] {
        D_NONE, D_HC, D_HS, D_N2, D_BEX, D_BEY, D_BDX, D_BDY,
        D_IX, D_IY, D_TX, D_TXA, D_TY, D_TYA, D_YI, D_YAW
    } t_dst;

    // One multiply-accumulate step: hi selects the upper 16-bit half of B
    typedef struct packed {
        t_asel a;
        t_bsel b;
        logic  hi;
        logic  clr;
        logic  sub;
        t_dst  dst;
    } t_uop;

    function automatic t_uop mk(input t_asel a, input t_bsel b, input logic hi,
                                input logic clr, input logic sub, input t_dst dst);
        t_uop u;
        u.a   = a;
        u.b   = b;
        u.hi  = hi;
        u.clr = clr;
        u.sub = sub;
        u.dst = dst;
        return u;
    endfunction

    function automatic t_uop pyc_uop(input logic [5:0] pc);
        t_uop u;
        unique case (pc)
            6'd0:  u = mk(A_QW,  B_QW,  1'b0, 1'b1, 1'b0, D_NONE);
            6'd1:  u = mk(A_QX,  B_QX,  1'b0, 1'b0, 1'b0, D_HC);
            6'd2:  u = mk(A_QX,  B_QY,  1'b0, 1'b1, 1'b0, D_NONE);
            6'd3:  u = mk(A_QW,  B_QZ,  1'b0, 1'b0, 1'b0, D_HS);
            6'd4:  u = mk(A_HC,  B_HC,  1'b0, 1'b1, 1'b0, D_NONE);
            6'd5:  u = mk(A_HC,  B_HC,  1'b1, 1'b0, 1'b0, D_NONE);
            6'd6:  u = mk(A_HS,  B_HS,  1'b0, 1'b0, 1'b0, D_NONE);
            6'd7:  u = mk(A_HS,  B_HS,  1'b1, 1'b0, 1'b0, D_N2);
            6'd8:  u = mk(A_EX,  B_C,   1'b0, 1'b1, 1'b0, D_NONE);
            6'd9:  u = mk(A_EX,  B_C,   1'b1, 1'b0, 1'b0, D_NONE);
            6'd10: u = mk(A_EY,  B_S,   1'b0, 1'b0, 1'b0, D_NONE);
            6'd11: u = mk(A_EY,  B_S,   1'b1, 1'b0, 1'b0, D_BEX);
            6'd12: u = mk(A_EY,  B_C,   1'b0, 1'b1, 1'b0, D_NONE);
            6'd13: u = mk(A_EY,  B_C,   1'b1, 1'b0, 1'b0, D_NONE);
            6'd14: u = mk(A_EX,  B_S,   1'b0, 1'b0, 1'b1, D_NONE);
            6'd15: u = mk(A_EX,  B_S,   1'b1, 1'b0, 1'b1, D_BEY);
            6'd16: u = mk(A_DX,  B_C,   1'b0, 1'b1, 1'b0, D_NONE);
            6'd17: u = mk(A_DX,  B_C,   1'b1, 1'b0, 1'b0, D_NONE);
            6'd18: u = mk(A_DY,  B_S,   1'b0, 1'b0, 1'b0, D_NONE);
            6'd19: u = mk(A_DY,  B_S,   1'b1, 1'b0, 1'b0, D_BDX);
            6'd20: u = mk(A_DY,  B_C,   1'b0, 1'b1, 1'b0, D_NONE);
            6'd21: u = mk(A_DY,  B_C,   1'b1, 1'b0, 1'b0, D_NONE);
            6'd22: u = mk(A_DX,  B_S,   1'b0, 1'b0, 1'b1, D_NONE);
            6'd23: u = mk(A_DX,  B_S,   1'b1, 1'b0, 1'b1, D_BDY);
            6'd24: u = mk(A_BEX, B_KI,  1'b0, 1'b1, 1'b0, D_NONE);
            6'd25: u = mk(A_BEX, B_KI,  1'b1, 1'b0, 1'b0, D_IX);
            6'd26: u = mk(A_BEY, B_KI,  1'b0, 1'b1, 1'b0, D_NONE);
            6'd27: u = mk(A_BEY, B_KI,  1'b1, 1'b0, 1'b0, D_IY);
            6'd28: u = mk(A_BEX, B_KP,  1'b0, 1'b1, 1'b0, D_NONE);
            6'd29: u = mk(A_BEX, B_KP,  1'b1, 1'b0, 1'b0, D_TX);
            6'd30: u = mk(A_BDX, B_KD,  1'b0, 1'b1, 1'b0, D_NONE);
            6'd31: u = mk(A_BDX, B_KD,  1'b1, 1'b0, 1'b0, D_TXA);
            6'd32: u = mk(A_BEY, B_KP,  1'b0, 1'b1, 1'b0, D_NONE);
            6'd33: u = mk(A_BEY, B_KP,  1'b1, 1'b0, 1'b0, D_TY);
            6'd34: u = mk(A_BDY, B_KD,  1'b0, 1'b1, 1'b0, D_NONE);
            6'd35: u = mk(A_BDY, B_KD,  1'b1, 1'b0, 1'b0, D_TYA);
            6'd36: u = mk(A_ERR, B_YKI, 1'b0, 1'b1, 1'b0, D_NONE);
            6'd37: u = mk(A_ERR, B_YKI, 1'b1, 1'b0, 1'b0, D_YI);
            6'd38: u = mk(A_ERR, B_YKP, 1'b0, 1'b1, 1'b0, D_NONE);
            6'd39: u = mk(A_ERR, B_YKP, 1'b1, 1'b0, 1'b0, D_YAW);
            default: u = mk(A_QW, B_QW, 1'b0, 1'b1, 1'b0, D_NONE);
        endcase
        return u;
    endfunction

    // CORDIC arctangent step angles, Q.28
    function automatic logic signed [33:0] pyc_atan(input logic [4:0] i);
        logic signed [33:0] a;
        unique case (i)
            5'd0: a = 34'sd210828714;
            5'd1: a = 34'sd124459457;
            5'd2: a = 34'sd65760959;
            5'd3: a = 34'sd33381290;
            5'd4: a = 34'sd16755422;
            5'd5: a = 34'sd8385879;
            5'd6: a = 34'sd4193963;
            5'd7: a = 34'sd2097109;
            5'd8: a = 34'sd1048571;
            5'd9: a = 34'sd524287;
            default: a = 34'sd1 <<< (5'd28 - i);
        endcase
        return a;
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [71:0] v);
        logic signed [47:0] r;
        if (v > 72'sh00_0000_7FFF_FFFF_FFFF)
            r = 48'sh7FFF_FFFF_FFFF;
        else if (v < -72'sh00_0000_8000_0000_0000)
            r = -48'sh8000_0000_0000;
        else
            r = 48'(v);
        return r;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [71:0] v);
        logic [31:0] r;
        if (v > 72'sh7FFF_FFFF)
            r = 32'h7FFF_FFFF;
        else if (v < -72'sh8000_0000)
            r = 32'h8000_0000;
        else
            r = 32'(v);
        return r;
    endfunction

endpackage

### rtl/core/pyc_cordic.sv
// ----------------------------------------------------------------------------
// pyc_cordic
// One vectoring CORDIC lane: atan2(y, x) in Q.28, one iteration per step.
// ----------------------------------------------------------------------------
module pyc_cordic (
    input  logic               i_clk,
    input  logic               i_init,
    input  logic               i_step,
    input  logic [4:0]         i_iter,
    input  logic signed [33:0] i_x,
    input  logic signed [33:0] i_y,
    output logic signed [33:0] o_z
);

    logic signed [37:0] r_x, r_y, n_x, n_y;
    logic signed [33:0] r_z, n_z;
    logic               r_done;
    logic signed [37:0] w_xs, w_ys;
    logic signed [33:0] w_ang;

    assign w_xs  = r_x >>> i_iter;
    assign w_ys  = r_y >>> i_iter;
    assign w_ang = pyc_pkg::pyc_atan(i_iter);

    always_comb begin
        if (!r_y[37]) begin
            n_x = r_x + w_ys;
            n_y = r_y - w_xs;
            n_z = r_z + w_ang;
        end else begin
            n_x = r_x - w_ys;
            n_y = r_y + w_xs;
            n_z = r_z - w_ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_init) begin
            // on the axis: no rotation needed
            if (i_y == '0) begin
                r_done <= 1'b1;
                r_z    <= i_x[33] ? 34'(pyc_pkg::Q28_PI) : '0;
                r_x    <= 38'(i_x);
                r_y    <= '0;
            end else if (i_x[33]) begin
                r_done <= 1'b0;
                r_z    <= i_y[33] ? -34'(pyc_pkg::Q28_PI) : 34'(pyc_pkg::Q28_PI);
                r_x    <= -38'(i_x);
                r_y    <= -38'(i_y);
            end else begin
                r_done <= 1'b0;
                r_z    <= '0;
                r_x    <= 38'(i_x);
                r_y    <= 38'(i_y);
            end
        end else if (i_step && !r_done) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_z = r_z;

endmodule

### rtl/core/pyc_ctrl.sv
// ----------------------------------------------------------------------------
// pyc_ctrl
// Sequencer: walks one word through heading, sqrt, divide, rotation/PID,
// CORDIC and yaw phases, and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module pyc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  logic            i_m_tready,
    output logic            o_m_tvalid,
    output pyc_pkg::t_cmd   o_cmd
);

    pyc_pkg::t_state r_state, n_state;
    logic [5:0]      r_pc;
    logic [4:0]      r_iter;
    logic            r_out_valid;
    logic            w_load;

    assign w_load = (r_state == pyc_pkg::S_OUT) && (!r_out_valid || i_m_tready);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pyc_pkg::S_IDLE:  if (i_s_tvalid) n_state = pyc_pkg::S_HEAD;
            pyc_pkg::S_HEAD:  if (r_pc == pyc_pkg::PC_HEAD_END) n_state = pyc_pkg::S_SQRTI;
            pyc_pkg::S_SQRTI: n_state = pyc_pkg::S_SQRT;
            pyc_pkg::S_SQRT:  if (r_iter == pyc_pkg::SQRT_LAST) n_state = pyc_pkg::S_DIVI;
            pyc_pkg::S_DIVI:  n_state = pyc_pkg::S_DIV;
            pyc_pkg::S_DIV:   if (r_iter == pyc_pkg::DIV_LAST) n_state = pyc_pkg::S_ROT;
            pyc_pkg::S_ROT:   if (r_pc == pyc_pkg::PC_ROT_END) n_state = pyc_pkg::S_CORDI;
            pyc_pkg::S_CORDI: n_state = pyc_pkg::S_CORD;
            pyc_pkg::S_CORD:  if (r_iter == pyc_pkg::CORD_LAST) n_state = pyc_pkg::S_WRAP;
            pyc_pkg::S_WRAP:  n_state = pyc_pkg::S_YAW;
            pyc_pkg::S_YAW:   if (r_pc == pyc_pkg::PC_YAW_END) n_state = pyc_pkg::S_OUT;
            pyc_pkg::S_OUT:   if (w_load) n_state = pyc_pkg::S_IDLE;
            default:          n_state = pyc_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd.pc   = r_pc;
        o_cmd.iter = r_iter;
        o_cmd.op   = pyc_pkg::OP_NOP;
        o_s_tready = 1'b0;
        unique case (r_state)
            pyc_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) o_cmd.op = pyc_pkg::OP_CAPTURE;
            end
            pyc_pkg::S_HEAD, pyc_pkg::S_ROT, pyc_pkg::S_YAW: o_cmd.op = pyc_pkg::OP_MAC;
            pyc_pkg::S_SQRTI: o_cmd.op = pyc_pkg::OP_SQRT_INIT;
            pyc_pkg::S_SQRT:  o_cmd.op = pyc_pkg::OP_SQRT_STEP;
            pyc_pkg::S_DIVI:  o_cmd.op = pyc_pkg::OP_DIV_INIT;
            pyc_pkg::S_DIV:   o_cmd.op = pyc_pkg::OP_DIV_STEP;
            pyc_pkg::S_CORDI: o_cmd.op = pyc_pkg::OP_CORD_INIT;
            pyc_pkg::S_CORD:  o_cmd.op = pyc_pkg::OP_CORD_STEP;
            pyc_pkg::S_WRAP:  o_cmd.op = pyc_pkg::OP_WRAP;
            pyc_pkg::S_OUT:   if (w_load) o_cmd.op = pyc_pkg::OP_RESULT;
            default:          o_cmd.op = pyc_pkg::OP_NOP;
        endcase
    end

    assign o_m_tvalid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pyc_pkg::S_IDLE;
            r_pc        <= '0;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load)
                r_out_valid <= 1'b1;
            else if (i_m_tready)
                r_out_valid <= 1'b0;
            unique case (r_state)
                pyc_pkg::S_IDLE: r_pc <= '0;
                pyc_pkg::S_HEAD, pyc_pkg::S_ROT, pyc_pkg::S_YAW: r_pc <= r_pc + 6'd1;
                default: r_pc <= r_pc;
            endcase
            unique case (r_state)
                pyc_pkg::S_SQRTI, pyc_pkg::S_DIVI, pyc_pkg::S_CORDI: r_iter <= '0;
                pyc_pkg::S_SQRT, pyc_pkg::S_DIV, pyc_pkg::S_CORD: r_iter <= r_iter + 5'd1;
                default: r_iter <= r_iter;
            endcase
        end
    end

endmodule

### rtl/core/pyc_dp.sv
// ----------------------------------------------------------------------------
// pyc_dp
// Datapath: config registers, shared 36x17 multiply-accumulate, square root,
// two divider lanes, two CORDIC lanes, integrators and result registers.
// ----------------------------------------------------------------------------
module pyc_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pyc_pkg::t_cmd   i_cmd,
    input  logic [191:0]    i_s_tdata,
    input  logic            i_cfg_we,
    input  logic [2:0]      i_cfg_addr,
    input  logic [31:0]     i_cfg_data,
    output logic [95:0]     o_m_tdata,
    output logic            o_m_tuser
);

    // configuration
    logic [31:0] r_spx, r_spy, r_kp, r_ki, r_kd, r_ykp, r_yki;

    // captured word
    logic signed [31:0] r_px, r_py, r_vx, r_vy;
    logic signed [15:0] r_qw, r_qx, r_qy, r_qz;

    // working registers
    logic signed [71:0] r_acc, n_acc;
    logic signed [31:0] r_hc, r_hs;
    logic [63:0]        r_n2;
    logic [63:0]        r_sq_v;
    logic [33:0]        r_sq_rem;
    logic [31:0]        r_root;
    logic [31:0]        r_dc_rem, r_ds_rem, r_dc_num, r_ds_num, r_qc, r_qs;
    logic signed [35:0] r_bex, r_bey, r_bdx, r_bdy, r_err;
    logic signed [47:0] r_ix, r_iy, r_yi;
    logic signed [49:0] r_tx, r_ty, r_yaw;
    logic [31:0]        r_roll, r_pitch, r_yawc;
    logic               r_deg;

    pyc_pkg::t_uop      w_uop;
    logic signed [35:0] w_a;
    logic signed [16:0] w_b;
    logic signed [52:0] w_prod;
    logic signed [71:0] w_term;
    logic signed [32:0] w_ex, w_ey;
    logic signed [31:0] w_c, w_s;
    logic               w_deg;
    logic signed [33:0] w_zp, w_zh;
    logic signed [35:0] w_dz, w_wrap;

    // sqrt step
    logic [35:0] w_rem_t, w_trial;
    // divider steps
    logic [32:0] w_dc_r2, w_ds_r2;
    logic [63:0] w_num_c, w_num_s;
    logic [31:0] w_mc, w_ms;

    // post-processing of the accumulator
    logic signed [71:0] w_r30, w_r16, w_r24, w_r28, w_r36, w_ixr, w_iyr, w_yir;

    assign w_uop  = pyc_pkg::pyc_uop(i_cmd.pc);
    assign w_ex   = 33'($signed(r_spx)) - 33'(r_px);
    assign w_ey   = 33'($signed(r_spy)) - 33'(r_py);
    assign w_deg  = (r_hc == '0) && (r_hs == '0);
    assign w_c    = w_deg ? 32'sh4000_0000 : (r_hc[31] ? -$signed(r_qc) : $signed(r_qc));
    assign w_s    = w_deg ? 32'sd0 : (r_hs[31] ? -$signed(r_qs) : $signed(r_qs));

    always_comb begin
        unique case (w_uop.a)
            pyc_pkg::A_QW:  w_a = 36'(r_qw);
            pyc_pkg::A_QX:  w_a = 36'(r_qx);
            pyc_pkg::A_HC:  w_a = 36'(r_hc);
            pyc_pkg::A_HS:  w_a = 36'(r_hs);
            pyc_pkg::A_EX:  w_a = 36'(w_ex);
            pyc_pkg::A_EY:  w_a = 36'(w_ey);
            pyc_pkg::A_DX:  w_a = -36'(r_vx);
            pyc_pkg::A_DY:  w_a = -36'(r_vy);
            pyc_pkg::A_BEX: w_a = r_bex;
            pyc_pkg::A_BEY: w_a = r_bey;
            pyc_pkg::A_BDX: w_a = r_bdx;
            pyc_pkg::A_BDY: w_a = r_bdy;
            pyc_pkg::A_ERR: w_a = r_err;
            default:        w_a = '0;
        endcase
    end

    always_comb begin
        unique case (w_uop.b)
            pyc_pkg::B_QW:  w_b = 17'(r_qw);
            pyc_pkg::B_QX:  w_b = 17'(r_qx);
            pyc_pkg::B_QY:  w_b = 17'(r_qy);
            pyc_pkg::B_QZ:  w_b = 17'(r_qz);
            pyc_pkg::B_HC:  w_b = w_uop.hi ? 17'($signed(r_hc[31:16])) : {1'b0, r_hc[15:0]};
            pyc_pkg::B_HS:  w_b = w_uop.hi ? 17'($signed(r_hs[31:16])) : {1'b0, r_hs[15:0]};
            pyc_pkg::B_C:   w_b = w_uop.hi ? 17'($signed(w_c[31:16])) : {1'b0, w_c[15:0]};
            pyc_pkg::B_S:   w_b = w_uop.hi ? 17'($signed(w_s[31:16])) : {1'b0, w_s[15:0]};
            pyc_pkg::B_KP:  w_b = w_uop.hi ? {1'b0, r_kp[31:16]}  : {1'b0, r_kp[15:0]};
            pyc_pkg::B_KI:  w_b = w_uop.hi ? {1'b0, r_ki[31:16]}  : {1'b0, r_ki[15:0]};
            pyc_pkg::B_KD:  w_b = w_uop.hi ? {1'b0, r_kd[31:16]}  : {1'b0, r_kd[15:0]};
            pyc_pkg::B_YKP: w_b = w_uop.hi ? {1'b0, r_ykp[31:16]} : {1'b0, r_ykp[15:0]};
            pyc_pkg::B_YKI: w_b = w_uop.hi ? {1'b0, r_yki[31:16]} : {1'b0, r_yki[15:0]};
            default:        w_b = '0;
        endcase
    end

    assign w_prod = w_a * w_b;
    assign w_term = w_uop.hi ? (72'(w_prod) <<< 16) : 72'(w_prod);
    assign n_acc  = (w_uop.clr ? 72'sd0 : r_acc) + (w_uop.sub ? -w_term : w_term);

    // round half up at each target scale
    assign w_r30 = (n_acc + 72'sd536870912) >>> 30;
    assign w_r16 = (n_acc + 72'sd32768) >>> 16;
    assign w_r24 = (n_acc + 72'sd8388608) >>> 24;
    assign w_r28 = (n_acc + 72'sd134217728) >>> 28;
    assign w_r36 = (n_acc + 72'sd34359738368) >>> 36;
    assign w_ixr = (72'(r_ix) + 72'sd32768) >>> 16;
    assign w_iyr = (72'(r_iy) + 72'sd32768) >>> 16;
    assign w_yir = (72'(r_yi) + 72'sd32768) >>> 16;

    // sqrt: two radicand bits per step
    assign w_rem_t = {r_sq_rem, r_sq_v[63:62]};
    assign w_trial = {2'b00, r_root, 2'b01};

    // restoring divide: one quotient bit per step
    assign w_dc_r2 = {r_dc_rem, r_dc_num[31]};
    assign w_ds_r2 = {r_ds_rem, r_ds_num[31]};
    assign w_mc    = r_hc[31] ? 32'(-r_hc) : 32'(r_hc);
    assign w_ms    = r_hs[31] ? 32'(-r_hs) : 32'(r_hs);
    assign w_num_c = ({32'd0, w_mc} << 30) + {33'd0, r_root[31:1]};
    assign w_num_s = ({32'd0, w_ms} << 30) + {33'd0, r_root[31:1]};

    pyc_cordic u_cord_p (
        .i_clk  (i_clk),
        .i_init (i_cmd.op == pyc_pkg::OP_CORD_INIT),
        .i_step (i_cmd.op == pyc_pkg::OP_CORD_STEP),
        .i_iter (i_cmd.iter),
        .i_x    (-34'(r_px)),
        .i_y    (-34'(r_py)),
        .o_z    (w_zp)
    );

    pyc_cordic u_cord_h (
        .i_clk  (i_clk),
        .i_init (i_cmd.op == pyc_pkg::OP_CORD_INIT),
        .i_step (i_cmd.op == pyc_pkg::OP_CORD_STEP),
        .i_iter (i_cmd.iter),
        .i_x    (34'(w_c)),
        .i_y    (34'(w_s)),
        .o_z    (w_zh)
    );

    assign w_dz = 36'(w_zp) - 36'(w_zh);
    always_comb begin
        if (w_dz >= pyc_pkg::Q28_PI)
            w_wrap = w_dz - pyc_pkg::Q28_TWO_PI;
        else if (w_dz < -pyc_pkg::Q28_PI)
            w_wrap = w_dz + pyc_pkg::Q28_TWO_PI;
        else
            w_wrap = w_dz;
    end

    // config and integrators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spx <= pyc_pkg::RST_SETPOINT_X;
            r_spy <= pyc_pkg::RST_SETPOINT_Y;
            r_kp  <= pyc_pkg::RST_POS_KP;
            r_ki  <= pyc_pkg::RST_POS_KI_DT;
            r_kd  <= pyc_pkg::RST_POS_KD;
            r_ykp <= pyc_pkg::RST_YAW_KP;
            r_yki <= pyc_pkg::RST_YAW_KI_DT;
            r_ix  <= '0;
            r_iy  <= '0;
            r_yi  <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    pyc_pkg::REG_SETPOINT_X: r_spx <= i_cfg_data;
                    pyc_pkg::REG_SETPOINT_Y: r_spy <= i_cfg_data;
                    pyc_pkg::REG_POS_KP:     r_kp  <= i_cfg_data;
                    pyc_pkg::REG_POS_KI_DT:  r_ki  <= i_cfg_data;
                    pyc_pkg::REG_POS_KD:     r_kd  <= i_cfg_data;
                    pyc_pkg::REG_YAW_KP:     r_ykp <= i_cfg_data;
                    pyc_pkg::REG_YAW_KI_DT:  r_yki <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.op == pyc_pkg::OP_MAC) begin
                if (w_uop.dst == pyc_pkg::D_IX) r_ix <= pyc_pkg::sat48(72'(r_ix) + w_r16);
                if (w_uop.dst == pyc_pkg::D_IY) r_iy <= pyc_pkg::sat48(72'(r_iy) + w_r16);
                if (w_uop.dst == pyc_pkg::D_YI) r_yi <= pyc_pkg::sat48(72'(r_yi) + w_r28);
            end
        end
    end

    // working datapath
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            pyc_pkg::OP_CAPTURE: begin
                r_px <= i_s_tdata[31:0];
                r_py <= i_s_tdata[63:32];
                r_vx <= i_s_tdata[95:64];
                r_vy <= i_s_tdata[127:96];
                r_qw <= i_s_tdata[143:128];
                r_qx <= i_s_tdata[159:144];
                r_qy <= i_s_tdata[175:160];
                r_qz <= i_s_tdata[191:176];
            end
            pyc_pkg::OP_MAC: begin
                r_acc <= n_acc;
                unique case (w_uop.dst)
                    pyc_pkg::D_HC:  r_hc  <= 32'((n_acc - 72'sd134217728) >>> 1);
                    pyc_pkg::D_HS:  r_hs  <= 32'(n_acc >>> 1);
                    pyc_pkg::D_N2:  r_n2  <= n_acc[63:0];
                    pyc_pkg::D_BEX: r_bex <= 36'(w_r30);
                    pyc_pkg::D_BEY: r_bey <= 36'(w_r30);
                    pyc_pkg::D_BDX: r_bdx <= 36'(w_r30);
                    pyc_pkg::D_BDY: r_bdy <= 36'(w_r30);
                    pyc_pkg::D_TX:  r_tx  <= 50'(w_r24 + w_ixr);
                    pyc_pkg::D_TXA: r_tx  <= 50'(72'(r_tx) + w_r24);
                    pyc_pkg::D_TY:  r_ty  <= 50'(w_r24 + w_iyr);
                    pyc_pkg::D_TYA: r_ty  <= 50'(72'(r_ty) + w_r24);
                    pyc_pkg::D_YAW: r_yaw <= 50'(w_r36 + w_yir);
                    default: ;
                endcase
            end
            pyc_pkg::OP_SQRT_INIT: begin
                r_sq_v   <= r_n2;
                r_sq_rem <= '0;
                r_root   <= '0;
            end
            pyc_pkg::OP_SQRT_STEP: begin
                r_sq_v <= r_sq_v << 2;
                if (w_rem_t >= w_trial) begin
                    r_sq_rem <= 34'(w_rem_t - w_trial);
                    r_root   <= {r_root[30:0], 1'b1};
                end else begin
                    r_sq_rem <= w_rem_t[33:0];
                    r_root   <= {r_root[30:0], 1'b0};
                end
            end
            pyc_pkg::OP_DIV_INIT: begin
                // quotient fits 32 bits, so the upper half is already below the divisor
                r_dc_rem <= w_num_c[63:32];
                r_dc_num <= w_num_c[31:0];
                r_ds_rem <= w_num_s[63:32];
                r_ds_num <= w_num_s[31:0];
            end
            pyc_pkg::OP_DIV_STEP: begin
                r_dc_num <= r_dc_num << 1;
                r_ds_num <= r_ds_num << 1;
                if (w_dc_r2 >= {1'b0, r_root}) begin
                    r_dc_rem <= 32'(w_dc_r2 - {1'b0, r_root});
                    r_qc     <= {r_qc[30:0], 1'b1};
                end else begin
                    r_dc_rem <= w_dc_r2[31:0];
                    r_qc     <= {r_qc[30:0], 1'b0};
                end
                if (w_ds_r2 >= {1'b0, r_root}) begin
                    r_ds_rem <= 32'(w_ds_r2 - {1'b0, r_root});
                    r_qs     <= {r_qs[30:0], 1'b1};
                end else begin
                    r_ds_rem <= w_ds_r2[31:0];
                    r_qs     <= {r_qs[30:0], 1'b0};
                end
            end
            pyc_pkg::OP_WRAP: r_err <= w_wrap;
            pyc_pkg::OP_RESULT: begin
                r_roll  <= pyc_pkg::sat32(72'(r_ty));
                r_pitch <= pyc_pkg::sat32(-72'(r_tx));
                r_yawc  <= pyc_pkg::sat32(72'(r_yaw));
                r_deg   <= w_deg;
            end
            default: ;
        endcase
    end

    assign o_m_tdata = {r_yawc, r_pitch, r_roll};
    assign o_m_tuser = r_deg;

endmodule

### rtl/core/position_yaw_pid_controller.sv
// ----------------------------------------------------------------------------
// position_yaw_pid_controller
// Horizontal position PID with body-frame rotation and PI yaw-rate loop.
//
//   channel  dir  handshake                 payload
//   s        in   i_s_tvalid / o_s_tready   i_s_tdata: pos/vel/quaternion
//   m        out  o_m_tvalid / i_m_tready   o_m_tdata: commands, o_m_tuser
//   cfg      in   i_cfg_we                  i_cfg_addr, i_cfg_data
//
// Each word passes from acceptance to result through 32 sqrt steps,
// 32 divide steps, 28 CORDIC steps and 40 multiply-accumulate steps on the
// single shared multiplier. One word is in flight at a time; the next word
// is accepted while the previous result waits in the output register.
// Synchronous active-low reset restores register defaults and clears the
// integrators. A stalled output holds the sequencer at its final step.
// ----------------------------------------------------------------------------
module position_yaw_pid_controller (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // pos_x, pos_y, vel_x, vel_y (32 each), quat_w, quat_x, quat_y, quat_z (16 each)
    input  logic [191:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // roll_cmd, pitch_cmd, yaw rate command (32 each)
    output logic [95:0]  o_m_tdata,
    // heading_degenerate
    output logic         o_m_tuser,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_addr,
    input  logic [31:0]  i_cfg_data
);

    pyc_pkg::t_cmd w_cmd;

    pyc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_cmd      (w_cmd)
    );

    pyc_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_s_tdata  (i_s_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule
